[src/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger at one edge implies the consequence at the next edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[src/kdlr_pkg.sv]
`timescale 1ns / 1ps

package kdlr_pkg;

    localparam int CNT_W = 16;
    localparam int CFG_W = 16;
    localparam int CODE_W = 3;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [CFG_W-1:0] cfg_word_t;
    typedef logic [CODE_W-1:0] code_t;

    localparam cfg_word_t DEBOUNCE_RESET = cfg_word_t'(20);
    localparam cfg_word_t LONG_RESET = cfg_word_t'(1000);
    localparam cfg_word_t REPEAT_RESET = cfg_word_t'(100);

    localparam code_t KEY_NONE = code_t'(0);
    localparam code_t KEY_1 = code_t'(1);
    localparam code_t KEY_2 = code_t'(2);
    localparam code_t KEY_3 = code_t'(3);
    localparam code_t KEY_4 = code_t'(4);

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_REPEAT   = 2'd2
    } cfg_reg_t;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        code_t event_code;
        code_t stable_code;
        logic  event_waiting;
    } result_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == {CNT_W{1'b1}}) ? v : v + count_t'(1);
    endfunction

    // lowest key wins
    function automatic code_t encode_keys(input logic [3:0] keys);
        code_t c;
        if (keys[0])
            c = KEY_1;
        else if (keys[1])
            c = KEY_2;
        else if (keys[2])
            c = KEY_3;
        else if (keys[3])
            c = KEY_4;
        else
            c = KEY_NONE;
        return c;
    endfunction

endpackage

[src/key_debounce_longpress_repeat.sv]
`timescale 1ns / 1ps
// Output: each result is registered at its accept edge, in the skid if stalled.
// Throughput: one item per cycle while in_stall is low; one-pass state update.
// A two-entry output (result register plus skid) keeps in_stall registered.
// Reset: all key state and the mailbox clear; debounce/long/repeat registers
// return to 20/1000/100 ticks; no output beat is pending.

`include "assert_macros.svh"

module key_debounce_longpress_repeat
    import kdlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [3:0]  keys_pressed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_code,
    output logic [2:0]  stable_code,
    output logic        event_waiting,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_word_t debounce_reg, long_reg, repeat_reg;

    code_t  last_sample_reg, stable_key_reg, pending_event_reg;
    count_t same_count_reg, hold_count_reg, repeat_count_reg;
    logic   long_reported_reg;

    code_t  last_sample_next, stable_key_next, pending_event_next;
    count_t same_count_next, hold_count_next, repeat_count_next;
    logic   long_reported_next;
    result_t result_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic in_acc, out_pop;

    assign in_stall = skid_valid_reg;
    assign in_acc = in_valid && !skid_valid_reg;
    assign out_pop = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign event_code = out_reg.event_code;
    assign stable_code = out_reg.stable_code;
    assign event_waiting = out_reg.event_waiting;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg <= LONG_RESET;
            repeat_reg <= REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_LONG:     long_reg <= cfg_data;
                REG_REPEAT:   repeat_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        code_t raw;
        code_t was;
        code_t ev;

        last_sample_next = last_sample_reg;
        stable_key_next = stable_key_reg;
        pending_event_next = pending_event_reg;
        same_count_next = same_count_reg;
        hold_count_next = hold_count_reg;
        repeat_count_next = repeat_count_reg;
        long_reported_next = long_reported_reg;
        raw = encode_keys(keys_pressed);
        was = stable_key_reg;
        ev = KEY_NONE;

        if (kind == KIND_READ)
        begin
            ev = pending_event_reg;
            pending_event_next = KEY_NONE;
        end
        else
        begin
            if (raw == last_sample_reg)
                same_count_next = sat_inc(same_count_reg);
            else
            begin
                same_count_next = '0;
                last_sample_next = raw;
            end

            if (32'(same_count_next) >= 32'(debounce_reg) && raw != stable_key_reg)
            begin
                stable_key_next = raw;
                if (raw != KEY_NONE)
                begin
                    // new key or key change: restart hold timers
                    hold_count_next = '0;
                    repeat_count_next = '0;
                    long_reported_next = 1'b0;
                end
                else if (was != KEY_NONE && !long_reported_reg && pending_event_reg == KEY_NONE)
                    pending_event_next = was;  // short press on release
            end

            if (stable_key_next != KEY_NONE)
            begin
                hold_count_next = sat_inc(hold_count_next);
                if (!long_reported_next)
                begin
                    // long press retries while mailbox is full
                    if (32'(hold_count_next) >= 32'(long_reg)
                        && pending_event_next == KEY_NONE)
                    begin
                        pending_event_next = stable_key_next;
                        long_reported_next = 1'b1;
                        repeat_count_next = '0;
                    end
                end
                else
                begin
                    repeat_count_next = sat_inc(repeat_count_next);
                    if (32'(repeat_count_next) >= 32'(repeat_reg))
                    begin
                        repeat_count_next = '0;
                        if (pending_event_next == KEY_NONE)
                            pending_event_next = stable_key_next;
                    end
                end
            end
        end

        result_next.event_code = ev;
        result_next.stable_code = stable_key_next;
        result_next.event_waiting = (pending_event_next != KEY_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= KEY_NONE;
            stable_key_reg <= KEY_NONE;
            pending_event_reg <= KEY_NONE;
            same_count_reg <= '0;
            hold_count_reg <= '0;
            repeat_count_reg <= '0;
            long_reported_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            last_sample_reg <= last_sample_next;
            stable_key_reg <= stable_key_next;
            pending_event_reg <= pending_event_next;
            same_count_reg <= same_count_next;
            hold_count_reg <= hold_count_next;
            repeat_count_reg <= repeat_count_next;
            long_reported_reg <= long_reported_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
                skid_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
                out_reg <= skid_reg;
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_pop)
                out_reg <= result_next;
            else
                skid_reg <= result_next;
        end
    end

    `ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid beat without output beat")
    `ASSERT_ALWAYS(a_read_clears_flag, !out_valid_reg || out_reg.event_code == KEY_NONE || !out_reg.event_waiting, "read beat shows event still waiting")
    `ASSERT_NEXT(a_read_empties_box, in_acc && kind == KIND_READ, pending_event_reg == KEY_NONE, "mailbox not cleared by read")
    `ASSERT_NEXT(a_skid_holds, skid_valid_reg && out_stall, skid_valid_reg && out_valid_reg, "skid beat lost under stall")

endmodule
